// ===== src/hslcp_pkg.sv =====
// shared types and constants for the http status line code parser
// no dependencies; used by every module of the block
package hslcp_pkg;

    localparam int CODE_WIDTH_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 32;
    localparam int PREFIX_LEN     = 5;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // prefix match counter; pos_fail marks a line that is not a status line
    localparam logic [2:0] POS_FAIL = 3'd7;

    typedef enum logic [1:0] {
        PH_PRE_SPACE = 2'd0,
        PH_CODE      = 2'd1,
        PH_AFTER     = 2'd2
    } phase_t;

    // one accepted byte with its end marker
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } item_t;

    // expected character of "HTTP/" at a given prefix position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2f;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/hslcp_in_stage.sv =====
// input register of the http status line code parser
// depends on hslcp_pkg
module hslcp_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  hslcp_pkg::item_t s_item,
    output logic             item_valid,
    output hslcp_pkg::item_t item,
    input  logic             item_take
);
    import hslcp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (item_take) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/hslcp_line_core.sv =====
// line state, code accumulation and result register of the parser
// depends on hslcp_pkg
module hslcp_line_core #(
    parameter int CODE_WIDTH = hslcp_pkg::CODE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  hslcp_pkg::item_t              item,
    output logic                          item_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          code_found,
    output logic [hslcp_pkg::STATUS_W-1:0] status_value
);
    import hslcp_pkg::*;

    localparam int WIDE_W = (CODE_WIDTH > STATUS_W) ? CODE_WIDTH : STATUS_W;

    typedef struct packed {
        logic [2:0]            pos;
        logic                  matched;
        phase_t                phase;
        logic [CODE_WIDTH-1:0] acc;
        logic                  seen;
        logic                  invalid;
    } line_t;

    localparam line_t LINE_CLEAR = '{
        pos: 3'd0, matched: 1'b0, phase: PH_PRE_SPACE,
        acc: '0, seen: 1'b0, invalid: 1'b0
    };

    function automatic line_t take_char(input line_t s, input logic [BYTE_W-1:0] c);
        line_t             r;
        logic [CODE_WIDTH+3:0] ext;
        logic [CODE_WIDTH+3:0] sum;
        r   = s;
        ext = {4'b0, s.acc};
        sum = (ext << 3) + (ext << 1) + (CODE_WIDTH+4)'(c - CH_ZERO);
        if (!s.matched) begin
            if ((s.pos < 3'(PREFIX_LEN)) && (c == prefix_char(s.pos))) begin
                r.pos = s.pos + 3'd1;
                if (s.pos == 3'(PREFIX_LEN - 1)) begin
                    r.matched = 1'b1;
                end
            end else begin
                r.pos = POS_FAIL;
            end
        end else if (s.phase == PH_PRE_SPACE) begin
            if (c == CH_SPACE) begin
                r.phase = PH_CODE;
            end
        end else if (s.phase == PH_CODE) begin
            if (c == CH_SPACE) begin
                r.phase = PH_AFTER;
            end else if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
                if (sum[CODE_WIDTH+3:CODE_WIDTH] != 4'd0) begin
                    r.invalid = 1'b1;
                end else begin
                    r.acc = sum[CODE_WIDTH-1:0];
                end
                r.seen = 1'b1;
            end else begin
                r.invalid = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic line_counts(input line_t s);
        return s.matched && (s.phase != PH_PRE_SPACE) && s.seen && !s.invalid;
    endfunction

    line_t                 line_reg, line_next;
    logic                  pending_reg, pending_next;
    logic [CODE_WIDTH-1:0] kept_code_reg, kept_code_next;
    logic                  kept_valid_reg, kept_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  found_reg, found_next;
    logic [STATUS_W-1:0]   value_reg, value_next;

    line_t                 s0, s1;
    logic [CODE_WIDTH-1:0] kc;
    logic                  kv;
    logic [WIDE_W-1:0]     kc_wide;

    assign item_take    = item_valid && (!item.end_of_text || !m_valid_reg || m_tready);
    assign m_tvalid     = m_valid_reg;
    assign code_found   = found_reg;
    assign status_value = value_reg;

    always_comb begin
        line_next       = line_reg;
        pending_next    = pending_reg;
        kept_code_next  = kept_code_reg;
        kept_valid_next = kept_valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        found_next      = found_reg;
        value_next      = value_reg;
        s0              = line_reg;
        s1              = line_reg;
        kc              = kept_code_reg;
        kv              = kept_valid_reg;
        kc_wide         = WIDE_W'(kept_code_reg);
        if (item_take) begin
            // a held carriage return that is not followed by line feed is text
            if (pending_reg && (item.data_byte != CH_LF)) begin
                s0 = take_char(line_reg, CH_CR);
            end
            pending_next = 1'b0;
            if (item.data_byte == CH_LF) begin
                if (line_counts(s0)) begin
                    kc = s0.acc;
                    kv = 1'b1;
                end
                s1 = LINE_CLEAR;
            end else if (item.data_byte == CH_CR) begin
                pending_next = 1'b1;
                s1           = s0;
            end else begin
                s1 = take_char(s0, item.data_byte);
            end
            line_next       = s1;
            kept_code_next  = kc;
            kept_valid_next = kv;
            if (item.end_of_text) begin
                if (line_counts(s1)) begin
                    kc = s1.acc;
                    kv = 1'b1;
                end
                kc_wide         = WIDE_W'(kc);
                m_valid_next    = 1'b1;
                found_next      = kv;
                value_next      = kv ? kc_wide[STATUS_W-1:0] : '0;
                line_next       = LINE_CLEAR;
                pending_next    = 1'b0;
                kept_code_next  = '0;
                kept_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg       <= LINE_CLEAR;
            pending_reg    <= 1'b0;
            kept_code_reg  <= '0;
            kept_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            line_reg       <= line_next;
            pending_reg    <= pending_next;
            kept_code_reg  <= kept_code_next;
            kept_valid_reg <= kept_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        value_reg <= value_next;
    end

endmodule

// ===== src/http_status_line_code_parser.sv =====
// top level of the http status line code parser
// depends on hslcp_pkg, hslcp_in_stage and hslcp_line_core
//
// the block takes a header block as a byte stream, one byte per transaction,
// with s_tlast on the final byte, and splits it into lines on line feed (one
// carriage return right before a line end is dropped). a line that starts
// with "HTTP/" and whose text from the first space to the second space or
// line end is one or more decimal digits fitting in CODE_WIDTH bits sets the
// kept status code; the last such line wins. on the final byte exactly one
// result transaction leaves on the m_ side: m_tuser carries the found flag,
// m_tdata the code (low 32 bits, zero when nothing was found); all state then
// clears for the next block. each byte sits in an input register, and the
// line update (prefix match, multiply by ten and add with overflow check) is
// combinational into the line state and the result register, so a byte can
// be accepted on every clock edge. only a final byte stalls, and only while an
// earlier result is still waiting in the result register. a final byte passes
// the input register and then the result register before m_tvalid rises.
module http_status_line_code_parser #(
    parameter int CODE_WIDTH = hslcp_pkg::CODE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_text
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] status_value
    output logic [0:0]  m_tuser    // [0] code_found
);
    import hslcp_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  item_take;
    logic  code_found;

    assign s_item.data_byte   = s_tdata;
    assign s_item.end_of_text = s_tlast;
    assign m_tuser[0]         = code_found;

    // byte register in front of the line logic
    hslcp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // line parsing, kept code and result register
    hslcp_line_core #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_line_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .code_found   (code_found),
        .status_value (m_tdata)
    );

endmodule
